@@ hw/rtl/array_linked_list_engine_assert.svh @@
// assertion macros for the linked list engine checker
// expects clk and rst_n in the scope of use
`ifndef ARRAY_LINKED_LIST_ENGINE_ASSERT_SVH
`define ARRAY_LINKED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication
`define ALLE_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ALLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/alle_pkg.sv @@
// shared types and constants of the linked list engine
// no dependencies
package alle_pkg;

  localparam int DEF_SLOTS = 64;
  localparam int KIND_W    = 2;
  localparam int VALUE_W   = 32;
  localparam int IN_DATA_W = 2 * VALUE_W;
  localparam int STATUS_W  = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_AFTER  = 2'd0,
    KIND_BEFORE = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

endpackage

@@ hw/rtl/array_linked_list_engine.sv @@
// linked list engine: insert after/before or remove by key in a slot table
// trivial requests go from start straight to the result state; remove walks the
// list from the head, insert walks it, scans for a free slot, writes the node, then links it
// one transaction in flight, next one accepted once the result is registered to the output
// reset clears head link, node count and output valid, marks slots 1..SLOTS free
// value and link memories are not cleared, there is no clearing pass
module array_linked_list_engine #(
  parameter int  SLOTS  = alle_pkg::DEF_SLOTS,
  localparam int SLOT_W = $clog2(SLOTS + 1),
  localparam int OUT_W  = ((alle_pkg::STATUS_W + 2 * SLOT_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [alle_pkg::IN_DATA_W-1:0] in_tdata,   // key, new_value
  input  logic [alle_pkg::KIND_W-1:0]    in_tuser,   // kind
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_W-1:0]               out_tdata   // status, slot, count
);
  import alle_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_WALK, S_SCAN, S_INS_NEW, S_INS_LINK, S_RESULT
  } state_t;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS);
  localparam logic [SLOT_W-1:0] ONE_SLOT  = SLOT_W'(1);

  state_t                    state_r, state_nxt;
  kind_t                     kind_r, kind_nxt;
  logic signed [VALUE_W-1:0] key_r, key_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic [SLOT_W-1:0]         head_r, head_nxt;
  logic [SLOT_W-1:0]         count_r, count_nxt;
  logic [SLOT_W-1:0]         cur_r, cur_nxt;
  logic [SLOT_W-1:0]         prev_r, prev_nxt;
  logic [SLOT_W-1:0]         hit_link_r, hit_link_nxt;
  logic [SLOT_W-1:0]         fs_r, fs_nxt;
  logic [SLOT_W-1:0]         steps_r, steps_nxt;
  logic [SLOTS:0]            free_r, free_nxt;
  status_t                   res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]         res_slot_r, res_slot_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]          out_data_r, out_data_nxt;

  logic [SLOT_W-1:0]         link_mem [0:SLOTS];
  logic [VALUE_W-1:0]        val_mem  [0:SLOTS];
  logic [SLOT_W-1:0]         rd_link_r;
  logic signed [VALUE_W-1:0] rd_val_r;
  logic [SLOT_W-1:0]         rd_addr;
  logic [SLOT_W-1:0]         wr_addr;
  logic [SLOT_W-1:0]         wr_link;
  logic                      link_we;
  logic                      val_we;
  logic [SLOT_W-1:0]         steps_inc;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign steps_inc  = steps_r + ONE_SLOT;

  // link and value memories, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[wr_addr] <= wr_link;
    end
    rd_link_r <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[wr_addr] <= val_r;
    end
    rd_val_r <= val_mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    hit_link_nxt   = hit_link_r;
    fs_nxt         = fs_r;
    steps_nxt      = steps_r;
    free_nxt       = free_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    rd_addr        = cur_r;
    wr_addr        = fs_r;
    wr_link        = hit_link_r;
    link_we        = 1'b0;
    val_we         = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = kind_t'(in_tuser);
          key_nxt   = in_tdata[VALUE_W-1:0];
          val_nxt   = in_tdata[IN_DATA_W-1:VALUE_W];
          state_nxt = S_START;
        end
      end
      S_START: begin
        res_slot_nxt = '0;
        state_nxt    = S_RESULT;
        case (kind_r)
          KIND_AFTER, KIND_BEFORE: begin
            if (count_r >= LAST_SLOT) begin
              res_status_nxt = ST_FULL;
            end else if (count_r == '0) begin
              // empty list: key ignored, node goes to slot 1
              wr_addr        = ONE_SLOT;
              wr_link        = '0;
              link_we        = 1'b1;
              val_we         = 1'b1;
              head_nxt       = ONE_SLOT;
              free_nxt[1]    = 1'b0;
              count_nxt      = ONE_SLOT;
              res_status_nxt = ST_OK;
              res_slot_nxt   = ONE_SLOT;
            end else if (head_r == '0 || head_r > LAST_SLOT) begin
              res_status_nxt = ST_MISSING;
            end else begin
              cur_nxt   = head_r;
              prev_nxt  = '0;
              steps_nxt = '0;
              rd_addr   = head_r;
              state_nxt = S_WALK;
            end
          end
          KIND_REMOVE: begin
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
            end else if (head_r == '0 || head_r > LAST_SLOT) begin
              res_status_nxt = ST_MISSING;
            end else begin
              cur_nxt   = head_r;
              prev_nxt  = '0;
              steps_nxt = '0;
              rd_addr   = head_r;
              state_nxt = S_WALK;
            end
          end
          default: begin
            res_status_nxt = ST_MISSING;
          end
        endcase
      end
      S_WALK: begin
        if (rd_val_r == key_r) begin
          hit_link_nxt = rd_link_r;
          if (kind_r == KIND_REMOVE) begin
            if (prev_r == '0) begin
              head_nxt = rd_link_r;
            end else begin
              link_we = 1'b1;
              wr_addr = prev_r;
              wr_link = rd_link_r;
            end
            free_nxt[cur_r] = 1'b1;
            count_nxt       = count_r - ONE_SLOT;
            res_status_nxt  = ST_OK;
            res_slot_nxt    = cur_r;
            state_nxt       = S_RESULT;
          end else begin
            fs_nxt    = ONE_SLOT;
            state_nxt = S_SCAN;
          end
        end else if (steps_inc < LAST_SLOT && rd_link_r != '0 && rd_link_r <= LAST_SLOT) begin
          prev_nxt  = cur_r;
          cur_nxt   = rd_link_r;
          steps_nxt = steps_inc;
          rd_addr   = rd_link_r;
        end else begin
          res_status_nxt = ST_MISSING;
          res_slot_nxt   = '0;
          state_nxt      = S_RESULT;
        end
      end
      S_SCAN: begin
        // lowest free slot, one mark per cycle
        if (free_r[fs_r]) begin
          state_nxt = S_INS_NEW;
        end else if (fs_r == LAST_SLOT) begin
          res_status_nxt = ST_FULL;
          res_slot_nxt   = '0;
          state_nxt      = S_RESULT;
        end else begin
          fs_nxt = fs_r + ONE_SLOT;
        end
      end
      S_INS_NEW: begin
        val_we         = 1'b1;
        link_we        = 1'b1;
        wr_addr        = fs_r;
        wr_link        = (kind_r == KIND_AFTER) ? hit_link_r : cur_r;
        free_nxt[fs_r] = 1'b0;
        state_nxt      = S_INS_LINK;
      end
      S_INS_LINK: begin
        if (kind_r == KIND_AFTER) begin
          link_we = 1'b1;
          wr_addr = cur_r;
          wr_link = fs_r;
        end else if (prev_r == '0) begin
          head_nxt = fs_r;
        end else begin
          link_we = 1'b1;
          wr_addr = prev_r;
          wr_link = fs_r;
        end
        count_nxt      = count_r + ONE_SLOT;
        res_status_nxt = ST_OK;
        res_slot_nxt   = fs_r;
        state_nxt      = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'({count_r, res_slot_r, res_status_r});
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      free_r      <= {{SLOTS{1'b1}}, 1'b0};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    hit_link_r   <= hit_link_nxt;
    fs_r         <= fs_nxt;
    steps_r      <= steps_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

@@ hw/rtl/alle_checker.sv @@
// port-level checker for the linked list engine, bound to the top level
// depends on alle_pkg and array_linked_list_engine_assert.svh
`include "array_linked_list_engine_assert.svh"

module alle_checker #(
  parameter int  SLOTS  = alle_pkg::DEF_SLOTS,
  localparam int SLOT_W = $clog2(SLOTS + 1),
  localparam int OUT_W  = ((alle_pkg::STATUS_W + 2 * SLOT_W + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);
  import alle_pkg::*;

  logic [STATUS_W-1:0] st;
  logic [SLOT_W-1:0]   slot;
  logic [SLOT_W-1:0]   count;

  assign st    = out_tdata[STATUS_W-1:0];
  assign slot  = out_tdata[STATUS_W+SLOT_W-1:STATUS_W];
  assign count = out_tdata[STATUS_W+2*SLOT_W-1:STATUS_W+SLOT_W];

  `ALLE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `ALLE_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "second transaction taken while busy")
  `ALLE_ASSERT(a_slot_zero, out_tvalid && st != ST_OK, slot == '0, "slot nonzero on failed request")
  `ALLE_ASSERT(a_slot_range, out_tvalid && st == ST_OK, slot != '0 && slot <= SLOT_W'(SLOTS), "slot out of range")
  `ALLE_ASSERT(a_count_max, out_tvalid, count <= SLOT_W'(SLOTS), "count above slot total")

endmodule

bind array_linked_list_engine alle_checker #(.SLOTS(SLOTS)) u_alle_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
